### rtl/ksl_pkg.sv
// Shared definitions for the keyed slot table: sizes, operation and status
// codes, the flag update and flag view structs, and the free-slot search.
// Depends on nothing.
package ksl_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [31:0] REGISTERED_FLAG = 32'd1;

  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_READ       = 3'd2;
  localparam logic [2:0] OP_WRITE      = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_VALUE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic             en;
    logic             set_reg;
    logic             clr_reg;
    logic             set_val;
    logic             clr_val;
    logic             mark;
    logic [IDX_W-1:0] slot;
  } flag_update_t;

  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] free_idx;
    logic             registered;
    logic             has_value;
    logic             mark;
  } flag_view_t;

  function automatic logic [IDX_W-1:0] first_zero(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/ksl_value_ram.sv
// Value store of the keyed slot table: one write port, one registered read port.
// Depends on ksl_pkg for the depth and index width.
module ksl_value_ram
  import ksl_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [63:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [63:0]      rd_data
);

  logic [63:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ksl_flags.sv
// Per-slot registered, has-value and release-mark bits with the lowest free
// slot search. Depends on ksl_pkg for sizes, structs and first_zero.
module ksl_flags
  import ksl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  flag_update_t     upd,
  input  logic [IDX_W-1:0] rd_slot,
  output flag_view_t       view
);

  logic [ENTRIES-1:0] registered;
  logic [ENTRIES-1:0] has_value;
  logic [ENTRIES-1:0] mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= '0;
      has_value  <= '0;
      mark       <= '0;
    end else if (upd.en) begin
      if (upd.set_reg) begin
        registered[upd.slot] <= 1'b1;
      end
      if (upd.clr_reg) begin
        registered[upd.slot] <= 1'b0;
      end
      if (upd.set_val) begin
        has_value[upd.slot] <= 1'b1;
        mark[upd.slot]      <= upd.mark;
      end
      if (upd.clr_val) begin
        has_value[upd.slot] <= 1'b0;
        mark[upd.slot]      <= 1'b0;
      end
    end
  end

  always_comb begin
    view.full       = &registered;
    view.free_idx   = first_zero(registered);
    view.registered = registered[rd_slot];
    view.has_value  = has_value[rd_slot];
    view.mark       = mark[rd_slot];
  end

endmodule

### rtl/keyed_slot_table.sv
// Keyed slot table: 64 slots that are registered, unregistered, read, written
// and cleared through 64-bit keys. One operation is accepted every cycle unless
// the input is stalled by a blocked result. An accepted operation is registered
// into the stage that decides it while its slot value is read from a memory with
// a registered read port; its result is then loaded into the output register.
// All slot flags are clear after reset, with no clearing pass; the value memory
// is not reset. Depends on ksl_pkg, ksl_value_ram and ksl_flags.
module keyed_slot_table
  import ksl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [63:0] key,
  input  logic [63:0] value_in,
  input  logic        wants_release,
  input  logic        notify_release,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] key_out,
  output logic [63:0] read_value,
  output logic        release_valid,
  output logic [63:0] release_value
);

  logic        strict_check;
  logic        accept;
  logic        s1_valid;
  logic        s1_go;
  logic [2:0]  s1_op;
  logic [63:0] s1_key;
  logic [63:0] s1_value;
  logic        s1_wants;
  logic        s1_notify;
  logic        fwd_hit;
  logic [63:0] fwd_data;
  logic [63:0] rd_data;
  logic [63:0] cur_value;
  logic        ram_wr_en;

  logic [IDX_W-1:0] s1_slot;
  logic             key_ok;
  flag_update_t     upd;
  flag_view_t       view;

  logic [1:0]  status_next;
  logic [63:0] key_out_next;
  logic [63:0] read_value_next;
  logic        release_valid_next;
  logic [63:0] release_value_next;

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign s1_slot  = s1_key[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_check <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_check <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= ram_wr_en && (upd.slot == key[IDX_W-1:0]);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op;
      s1_key    <= key;
      s1_value  <= value_in;
      s1_wants  <= wants_release;
      s1_notify <= notify_release;
      fwd_data  <= s1_value;
    end
  end

  ksl_value_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_slot),
    .wr_data (s1_value),
    .rd_en   (accept),
    .rd_addr (key[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ksl_flags u_flags (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .rd_slot (s1_slot),
    .view    (view)
  );

  assign cur_value = fwd_hit ? fwd_data : rd_data;
  assign key_ok = (s1_key[63:32] == REGISTERED_FLAG) && (s1_key[31:0] < 32'(ENTRIES))
                  && (!strict_check || view.registered);

  always_comb begin
    status_next        = ST_OK;
    key_out_next       = '0;
    read_value_next    = '0;
    release_valid_next = 1'b0;
    release_value_next = '0;
    upd                = '0;
    upd.slot           = s1_slot;
    ram_wr_en          = 1'b0;
    priority if (s1_op == OP_REGISTER) begin
      if (view.full) begin
        status_next = ST_FULL;
      end else begin
        key_out_next = {REGISTERED_FLAG, {(32 - IDX_W){1'b0}}, view.free_idx};
        upd.en       = s1_go;
        upd.slot     = view.free_idx;
        upd.set_reg  = 1'b1;
        upd.clr_val  = 1'b1;
      end
    end else if (s1_op > OP_CLEAR || !key_ok) begin
      status_next = ST_INVALID;
    end else begin
      unique case (s1_op)
        OP_UNREGISTER: begin
          release_valid_next = s1_notify && view.has_value && view.mark;
          upd.en      = s1_go;
          upd.clr_reg = 1'b1;
          upd.clr_val = 1'b1;
        end
        OP_READ: begin
          if (!view.has_value) begin
            status_next = ST_NO_VALUE;
          end else begin
            read_value_next = cur_value;
          end
        end
        OP_WRITE: begin
          release_valid_next = s1_notify && view.has_value && view.mark;
          upd.en      = s1_go;
          upd.set_val = 1'b1;
          upd.mark    = s1_wants;
          ram_wr_en   = s1_go;
        end
        OP_CLEAR: begin
          if (!view.has_value) begin
            status_next = ST_NO_VALUE;
          end else begin
            release_valid_next = s1_notify && view.mark;
            upd.en      = s1_go;
            upd.clr_val = 1'b1;
          end
        end
        default: begin
          status_next = ST_INVALID;
        end
      endcase
      if (release_valid_next) begin
        release_value_next = cur_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      status        <= status_next;
      key_out       <= key_out_next;
      read_value    <= read_value_next;
      release_valid <= release_valid_next;
      release_value <= release_value_next;
    end
  end

`ifndef ASSERT_OFF
  a_go_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("Decided operation did not reach the output register.");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("Input stalled without a blocked operation in flight.");

  a_release_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_valid |-> status == ST_OK)
    else $error("Release reported on a failed operation.");

  a_failure_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> key_out == '0 && read_value == '0)
    else $error("Failed operation returned a key or a value.");
`endif

endmodule
